// ===== hdl/snll_pkg.sv =====
// Package for the signed number literal lexer.
// Holds phase and status codes, numeric limits, character constants and shared types.
// No dependencies.
`timescale 1ns / 1ps

package snll_pkg;

    // Scanner phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_SIGN = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_DEC  = 3'd3;
    localparam logic [2:0] PH_HEXX = 3'd4;
    localparam logic [2:0] PH_HEX  = 3'd5;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SIGN    = 3'd1;
    localparam logic [2:0] ST_LZERO   = 3'd2;
    localparam logic [2:0] ST_DECOVF  = 3'd3;
    localparam logic [2:0] ST_HEXLONG = 3'd4;
    localparam logic [2:0] ST_HEXNONE = 3'd5;
    localparam logic [2:0] ST_NEGRNG  = 3'd6;

    // Numeric limits
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;
    localparam logic [3:0]  DEC_BASE  = 4'd10;
    localparam logic [3:0]  HEX_MAX   = 4'd8;

    // ASCII codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;

    // Scanner state carried from one character to the next
    typedef struct packed {
        logic [2:0]  phase;
        logic        neg;
        logic [31:0] accum;
        logic [3:0]  hex_cnt;
    } snll_state_t;

    // One result beat
    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } snll_result_t;

endpackage

// ===== hdl/snll_char_if.sv =====
// Character channel: one input character or end-of-input mark per beat.
// No dependencies.
`timescale 1ns / 1ps

interface snll_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       at_eof;

    modport source (output valid, output ch, output at_eof, input ready);
    modport sink   (input valid, input ch, input at_eof, output ready);
endinterface

// ===== hdl/snll_result_if.sv =====
// Result channel: one literal value and status per beat.
// No dependencies.
`timescale 1ns / 1ps

interface snll_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [2:0]         status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ===== hdl/signed_number_literal_lexer_core.sv =====
// Signed 32-bit integer literal lexer, one character per beat.
// A character passes the input register and the scanner step; its result beat is registered.
// Throughput: one character per cycle unless results stall; decimal multiply-add sets the clock.
// Reset: rst_n clears both pipeline stages and returns the scanner to idle with no open literal.
// Depends on snll_pkg, snll_char_if, snll_result_if and snll_step.
`timescale 1ns / 1ps

module signed_number_literal_lexer_core
    import snll_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    snll_char_if.sink            chars,
    snll_result_if.source        results
);

    logic         in_valid_reg;
    logic [7:0]   ch_reg;
    logic         eof_reg;
    snll_state_t  state_reg;
    snll_state_t  state_next;
    logic         res_valid_reg;
    snll_result_t res_reg;
    logic         step_emit;
    snll_result_t step_result;
    logic         res_free;
    logic         step_go;

    // Handshake: the result register frees when empty or when its beat leaves.
    assign res_free    = !res_valid_reg || results.ready;
    assign step_go     = in_valid_reg && res_free;
    assign chars.ready = !in_valid_reg || res_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            ch_reg  <= chars.ch;
            eof_reg <= chars.at_eof;
        end
    end

    // Scanner step
    snll_step u_step (
        .state      (state_reg),
        .ch         (ch_reg),
        .at_eof     (eof_reg),
        .state_next (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            res_valid_reg <= step_emit;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step_emit)
        begin
            res_reg <= step_result;
        end
    end

    assign results.valid  = res_valid_reg;
    assign results.value  = res_reg.value;
    assign results.status = res_reg.status;

`ifndef SYNTH
    // A failed literal always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.status != ST_OK |-> res_reg.value == 32'sd0)
        else $error("error result with nonzero value");

    // Status codes stay within the defined range.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> res_reg.status <= ST_NEGRNG)
        else $error("result status out of range");

    // At most eight hex digits are ever gathered.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.hex_cnt <= HEX_MAX)
        else $error("hex digit count exceeds limit");

    // Idle means no literal is open: sign and magnitude are clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == PH_IDLE |-> !state_reg.neg && state_reg.accum == 32'd0)
        else $error("idle scanner holds a partial literal");

    // A stalled result stalls the scanner state.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !results.ready |=> $stable(state_reg))
        else $error("scanner advanced while result was held");
`endif

endmodule

// ===== hdl/snll_step.sv =====
// Next-state and result logic of the literal scanner for one character.
// Depends on snll_pkg.
`timescale 1ns / 1ps

module snll_step
    import snll_pkg::*;
(
    input  snll_state_t  state,
    input  logic [7:0]   ch,
    input  logic         at_eof,
    output snll_state_t  state_next,
    output logic         emit,
    output snll_result_t result
);

    // Hex digit value, or 16 when the character is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        begin
            v = 5'd16;
            if (c >= CH_0 && c <= CH_9)
            begin
                v = 5'(c - CH_0);
            end
            else if (c >= CH_A_LO && c <= CH_F_LO)
            begin
                v = 5'(c - CH_A_LO + 8'd10);
            end
            else if (c >= CH_A_UP && c <= CH_F_UP)
            begin
                v = 5'(c - CH_A_UP + 8'd10);
            end
            return v;
        end
    endfunction

    // State after a character is examined from idle; never gives a result.
    function automatic snll_state_t idle_start(input logic [7:0] c);
        snll_state_t s;
        begin
            s = '0;
            s.phase = PH_IDLE;
            if (c == CH_0)
            begin
                s.phase = PH_ZERO;
            end
            else if (c > CH_0 && c <= CH_9)
            begin
                s.accum = {24'd0, c - CH_0};
                s.phase = PH_DEC;
            end
            else if (c == CH_MINUS)
            begin
                s.neg   = 1'b1;
                s.phase = PH_SIGN;
            end
            else if (c == CH_PLUS)
            begin
                s.phase = PH_SIGN;
            end
            return s;
        end
    endfunction

    logic               is_dec;
    logic [3:0]         dec_digit;
    logic [4:0]         hex_digit;
    logic               is_hex;
    logic [35:0]        dec_acc;
    snll_state_t        restart;
    snll_result_t       fin_result;

    // Character classes
    assign is_dec    = (ch >= CH_0) && (ch <= CH_9);
    assign dec_digit = 4'(ch - CH_0);
    assign hex_digit = hex_value(ch);
    assign is_hex    = !hex_digit[4];

    // Decimal multiply-add; the top bits flag overflow past 32 bits.
    assign dec_acc = 36'(state.accum) * 36'(DEC_BASE) + 36'(dec_digit);

    // A terminator is examined again from idle; end of input just clears.
    assign restart = at_eof ? snll_state_t'('0) : idle_start(ch);

    // Closing a literal: negate a negative magnitude, check its range.
    always_comb
    begin
        fin_result.status = ST_OK;
        fin_result.value  = $signed(state.accum);
        if (state.neg)
        begin
            if (state.accum > NEG_LIMIT)
            begin
                fin_result.status = ST_NEGRNG;
                fin_result.value  = '0;
            end
            else
            begin
                fin_result.value = $signed(32'd0 - state.accum);
            end
        end
    end

    // Phase transitions
    always_comb
    begin
        state_next    = state;
        emit          = 1'b0;
        result.value  = '0;
        result.status = ST_OK;
        unique case (state.phase)
            PH_SIGN:
            begin
                if (at_eof || !is_dec)
                begin
                    emit          = 1'b1;
                    result.status = ST_SIGN;
                    state_next    = '0;
                end
                else if (ch == CH_0)
                begin
                    state_next.phase = PH_ZERO;
                end
                else
                begin
                    state_next.accum = 32'(dec_digit);
                    state_next.phase = PH_DEC;
                end
            end
            PH_ZERO:
            begin
                if (at_eof)
                begin
                    emit       = 1'b1;
                    state_next = '0;
                end
                else if (ch == CH_X_LO || ch == CH_X_UP)
                begin
                    state_next.phase = PH_HEXX;
                end
                else if (is_hex)
                begin
                    emit          = 1'b1;
                    result.status = ST_LZERO;
                    state_next    = '0;
                end
                else
                begin
                    emit       = 1'b1;
                    state_next = idle_start(ch);
                end
            end
            PH_DEC:
            begin
                if (!at_eof && is_dec)
                begin
                    if (dec_acc[35:32] != 4'd0)
                    begin
                        emit          = 1'b1;
                        result.status = ST_DECOVF;
                        state_next    = '0;
                    end
                    else
                    begin
                        state_next.accum = dec_acc[31:0];
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    result     = fin_result;
                    state_next = restart;
                end
            end
            PH_HEXX:
            begin
                if (at_eof || !is_hex)
                begin
                    emit          = 1'b1;
                    result.status = ST_HEXNONE;
                    state_next    = '0;
                end
                else
                begin
                    state_next.accum   = 32'(hex_digit[3:0]);
                    state_next.hex_cnt = 4'd1;
                    state_next.phase   = PH_HEX;
                end
            end
            PH_HEX:
            begin
                if (!at_eof && is_hex)
                begin
                    if (state.hex_cnt >= HEX_MAX)
                    begin
                        emit          = 1'b1;
                        result.status = ST_HEXLONG;
                        state_next    = '0;
                    end
                    else
                    begin
                        state_next.accum   = {state.accum[27:0], hex_digit[3:0]};
                        state_next.hex_cnt = state.hex_cnt + 4'd1;
                    end
                end
                else
                begin
                    emit       = 1'b1;
                    result     = fin_result;
                    state_next = restart;
                end
            end
            default:
            begin
                state_next = restart;
            end
        endcase
    end

endmodule

// ===== verif/snll_result_checker.sv =====
// Scoreboard for the signed number literal lexer: predicts each result beat and compares it.
// Watches the character and result channels; depends on snll_pkg and both channel interfaces.
`timescale 1ns / 1ps

module snll_result_checker
    import snll_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    snll_char_if    chars,
    snll_result_if  results,
    output int      fail_count,
    output int      pending,
    output int      checked,
    output int      kinds_seen
);

    // Predicted scanner state and the literals still owed by the block.
    snll_state_t  scan;
    snll_result_t literal_q[$];
    logic [6:0]   status_seen;

    initial
    begin
        scan        = '0;
        status_seen = '0;
        fail_count  = 0;
        pending     = 0;
        checked     = 0;
        kinds_seen  = 0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    // Hex digit value, or 16 when the byte is not a hex digit.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (is_digit(c))
            return 5'(c - CH_0);
        if ((c >= CH_A_LO) && (c <= CH_F_LO))
            return 5'(c - CH_A_LO + 8'd10);
        if ((c >= CH_A_UP) && (c <= CH_F_UP))
            return 5'(c - CH_A_UP + 8'd10);
        return 5'd16;
    endfunction

    // Begin scanning from idle; a byte that cannot open a literal leaves the scanner idle.
    function automatic void restart(input logic [7:0] c);
        scan = '0;
        if (c == CH_0)
            scan.phase = PH_ZERO;
        else if (is_digit(c))
        begin
            scan.accum = 32'(c - CH_0);
            scan.phase = PH_DEC;
        end
        else if (c == CH_MINUS)
        begin
            scan.neg   = 1'b1;
            scan.phase = PH_SIGN;
        end
        else if (c == CH_PLUS)
            scan.phase = PH_SIGN;
    endfunction

    function automatic snll_result_t fail_with(input logic [2:0] code);
        snll_result_t r;
        scan     = '0;
        r.value  = '0;
        r.status = code;
        return r;
    endfunction

    // Close an open literal; negative magnitudes beyond 2^31 are out of range.
    function automatic snll_result_t close_literal();
        snll_result_t r;
        r.status = ST_OK;
        if (!scan.neg)
            r.value = scan.accum;
        else if (scan.accum > NEG_LIMIT)
        begin
            r.value  = '0;
            r.status = ST_NEGRNG;
        end
        else
            r.value = 32'd0 - scan.accum;
        scan = '0;
        return r;
    endfunction

    // Advance the predicted scanner by one beat; returns 1 when a result is due.
    function automatic logic scan_char(input logic [7:0] c, input logic eof,
                                       output snll_result_t r);
        logic [63:0] grown;
        logic [4:0]  nib;
        nib = nibble_of(c);
        r   = '0;
        case (scan.phase)
            PH_SIGN:
            begin
                if (eof || !is_digit(c))
                begin
                    r = fail_with(ST_SIGN);
                    return 1'b1;
                end
                if (c == CH_0)
                    scan.phase = PH_ZERO;
                else
                begin
                    scan.accum = 32'(c - CH_0);
                    scan.phase = PH_DEC;
                end
                return 1'b0;
            end
            PH_ZERO:
            begin
                if (!eof && ((c == CH_X_LO) || (c == CH_X_UP)))
                begin
                    scan.phase = PH_HEXX;
                    return 1'b0;
                end
                if (!eof && (nib < 5'd16))
                begin
                    r = fail_with(ST_LZERO);
                    return 1'b1;
                end
                // A lone zero; negative zero is still zero.
                scan     = '0;
                r.value  = '0;
                r.status = ST_OK;
                if (!eof)
                    restart(c);
                return 1'b1;
            end
            PH_DEC:
            begin
                if (!eof && is_digit(c))
                begin
                    grown = {32'd0, scan.accum} * 64'(DEC_BASE) + 64'(c - CH_0);
                    if (grown[63:32] != 32'd0)
                    begin
                        r = fail_with(ST_DECOVF);
                        return 1'b1;
                    end
                    scan.accum = grown[31:0];
                    return 1'b0;
                end
                r = close_literal();
                if (!eof)
                    restart(c);
                return 1'b1;
            end
            PH_HEXX:
            begin
                if (eof || (nib >= 5'd16))
                begin
                    r = fail_with(ST_HEXNONE);
                    return 1'b1;
                end
                scan.accum   = 32'(nib[3:0]);
                scan.hex_cnt = 4'd1;
                scan.phase   = PH_HEX;
                return 1'b0;
            end
            PH_HEX:
            begin
                if (!eof && (nib < 5'd16))
                begin
                    if (scan.hex_cnt >= HEX_MAX)
                    begin
                        r = fail_with(ST_HEXLONG);
                        return 1'b1;
                    end
                    scan.accum   = {scan.accum[27:0], nib[3:0]};
                    scan.hex_cnt = scan.hex_cnt + 4'd1;
                    return 1'b0;
                end
                r = close_literal();
                if (!eof)
                    restart(c);
                return 1'b1;
            end
            default:
            begin
                // Idle: end of input does nothing; other bytes may open a literal.
                if (!eof)
                    restart(c);
                else
                    scan = '0;
                return 1'b0;
            end
        endcase
    endfunction

    // Predict on each accepted character beat, then check each accepted result beat.
    always @(posedge clk)
    begin
        snll_result_t due;
        snll_result_t want;
        if (!rst_n)
        begin
            scan = '0;
            literal_q.delete();
        end
        else
        begin
            if (chars.valid && chars.ready)
            begin
                if (scan_char(chars.ch, chars.at_eof, due))
                    literal_q.push_back(due);
            end
            if (results.valid && results.ready)
            begin
                checked++;
                if (literal_q.size() == 0)
                begin
                    $error("unexpected result beat: value %0d status %0d",
                           results.value, results.status);
                    fail_count++;
                end
                else
                begin
                    want = literal_q.pop_front();
                    status_seen[want.status] = 1'b1;
                    if (results.value !== want.value)
                    begin
                        $error("value mismatch: expected %0d, got %0d",
                               want.value, results.value);
                        fail_count++;
                    end
                    if (results.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, results.status);
                        fail_count++;
                    end
                end
            end
        end
        pending    = literal_q.size();
        kinds_seen = $countones(status_seen);
    end

endmodule

// ===== verif/tb.sv =====
// Top of the lexer testbench: clock, reset, character stimulus, result back-pressure, verdict.
// Depends on snll_pkg, the channel interfaces, the lexer core and snll_result_checker.
`timescale 1ns / 1ps

module tb;
    import snll_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 263;

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   stall_pct;
    int   sent_beats;
    int   noise_beats;
    int   cycles;
    int   fail_count;
    int   pending;
    int   checked;
    int   kinds_seen;

    // Idling plan per phase: none, sender idle, receiver stalling, both.
    int idle_plan[4]  = '{0, 54, 0, 34};
    int stall_plan[4] = '{0, 0, 54, 34};

    snll_char_if   chars_if ();
    snll_result_if results_if ();

    signed_number_literal_lexer_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if.sink),
        .results (results_if.source)
    );

    snll_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_if),
        .results    (results_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked),
        .kinds_seen (kinds_seen)
    );

    always #2 clk = ~clk;

    // Receiver back-pressure.
    always @(negedge clk)
    begin
        results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL signed_number_literal_lexer_core");
            $finish;
        end
    end

    // Drive one character beat, with optional idle cycles in front, and wait for acceptance.
    task automatic send_beat(input logic [7:0] c, input logic eof);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            @(negedge clk);
            chars_if.valid <= 1'b0;
        end
        @(negedge clk);
        chars_if.valid  <= 1'b1;
        chars_if.ch     <= c;
        chars_if.at_eof <= eof;
        do
            @(posedge clk);
        while (!chars_if.ready);
        sent_beats++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_eof();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Build one literal, well formed or deliberately broken, then usually a terminator.
    task automatic send_literal();
        string             s;
        int                pick;
        int                ndig;
        longint unsigned   dec_val;
        logic [31:0]       hex_pat;
        logic [3:0]        nib;
        logic [7:0]        c;
        s    = "";
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // Decimal, weighted toward the wrap, range and overflow boundaries.
            case ($urandom_range(0, 9))
                0:       dec_val = 64'd4294967295;
                1:       dec_val = 64'd4294967296;
                2:       dec_val = 64'd2147483648;
                3:       dec_val = 64'd2147483649;
                4:       dec_val = 64'd2147483647;
                5:       dec_val = {$urandom, $urandom} % 64'd1000000000000;
                6, 7:    dec_val = 64'($urandom);
                default: dec_val = 64'($urandom_range(1, 999));
            endcase
            s = $sformatf("%0d", dec_val);
        end
        else if (pick < 70)
        begin
            // Hex with 0 to 10 digits and mixed letter case.
            pick = $urandom_range(0, 99);
            if (pick < 8)
                ndig = 0;
            else if (pick < 85)
                ndig = $urandom_range(1, 8);
            else
                ndig = $urandom_range(9, 10);
            case ($urandom_range(0, 7))
                0:       hex_pat = 32'hFFFF_FFFF;
                1:       hex_pat = 32'h8000_0000;
                2:       hex_pat = 32'h8000_0001;
                3:       hex_pat = 32'h7FFF_FFFF;
                4:       hex_pat = 32'h0;
                default: hex_pat = $urandom;
            endcase
            s = $urandom_range(0, 1) ? "0x" : "0X";
            for (int i = ndig - 1; i >= 0; i--)
            begin
                nib = (i < 8) ? hex_pat[i*4 +: 4] : 4'($urandom_range(0, 15));
                if (nib < 4'd10)
                    c = CH_0 + 8'(nib);
                else
                    c = ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(nib) - 8'd10;
                s = $sformatf("%s%c", s, c);
            end
        end
        else if (pick < 86)
        begin
            // Zero followed by a digit: leading-zero error.
            s = $sformatf("0%0d", $urandom_range(0, 9));
        end
        else if (pick < 94)
            s = "0";

        // Sign prefix; an empty body leaves a sign alone.
        case ($urandom_range(0, 2))
            1:       s = {"+", s};
            2:       s = {"-", s};
            default: if (s.len() == 0) s = "-";
        endcase
        send_text(s);

        pick = $urandom_range(0, 99);
        if (pick < 20)
            send_eof();
        else if (pick < 55)
        begin
            case ($urandom_range(0, 3))
                0:       send_text(" ");
                1:       send_text(",");
                2:       send_text(";");
                default: send_text(")");
            endcase
        end
        else if (pick < 90)
            send_beat(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Random bytes and end-of-input marks that mostly land while idle.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            send_beat(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
            noise_beats++;
        end
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        cycles          = 0;
        sent_beats      = 0;
        noise_beats     = 0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        chars_if.valid  = 1'b0;
        chars_if.ch     = '0;
        chars_if.at_eof = 1'b0;
        results_if.ready = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: sign errors by byte and by end of input, leading zero, hex with no
        // digits both ways, negative zero, a terminator that opens the next literal,
        // a lone zero at end of input, and end of input while idle.
        send_text("+q");
        send_text("-");
        send_eof();
        send_text("07");
        send_text("0x");
        send_eof();
        send_text("0Xz");
        send_text("-0;");
        send_text("9-5");
        send_eof();
        send_text("0");
        send_eof();
        send_eof();

        // Random literals under each idling plan.
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_plan[p];
            stall_pct       = stall_plan[p];
            while ((sent_beats - noise_beats) < (p + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                send_literal();
            end
        end
        send_eof();

        // Drain: wait for every owed result, then let the clock run on before the verdict.
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d character beats (%0d noise) over four idling plans.",
                 sent_beats, noise_beats);
        $display("Checked %0d result beats covering %0d of 7 status codes.",
                 checked, kinds_seen);
        if (fail_count == 0)
            $display("PASS signed_number_literal_lexer_core");
        else
            $display("FAIL signed_number_literal_lexer_core");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/snll_pkg.sv
hdl/snll_char_if.sv
hdl/snll_result_if.sv
hdl/snll_step.sv
hdl/signed_number_literal_lexer_core.sv
verif/snll_result_checker.sv
verif/tb.sv
